// File: rtl/core/dsme_pkg.sv
// Shared constants, codes and types for the mark slot table.
package dsme_pkg;

  localparam int SLOTS = 16;
  localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW  = $clog2(SLOTS + 1);

  // operation codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // mark classes
  localparam logic [1:0] CLS_GLOW   = 2'd0;
  localparam logic [1:0] CLS_SCORCH = 2'd1;
  localparam logic [1:0] CLS_SCUFF  = 2'd2;
  localparam logic [1:0] CLS_RSVD   = 2'd3;

  // result actions
  localparam logic [2:0] ACT_MERGE      = 3'd0;
  localparam logic [2:0] ACT_FILL       = 3'd1;
  localparam logic [2:0] ACT_EVICT_GLOW = 3'd2;
  localparam logic [2:0] ACT_EVICT_OLD  = 3'd3;
  localparam logic [2:0] ACT_TICK       = 3'd4;
  localparam logic [2:0] ACT_READ       = 3'd5;

  // configuration register indexes
  localparam logic REG_MERGE_FACTOR = 1'b0;
  localparam logic REG_GLOW_LIFE    = 1'b1;

  localparam logic [14:0] FULL_LEVEL = 15'd16384;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REACH,
    ST_SQ,
    ST_SCAN
  } state_t;

  // item under work, broadcast to every cell
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  cls;
    logic        persist;
    logic [47:0] point;
    logic [47:0] normal;
    logic [47:0] tangent;
    logic [15:0] radius;
    logic [14:0] amt;
    logic [31:0] now;
    logic [3:0]  sel;
    logic [31:0] lifetime;
    logic [47:0] reach2;
  } item_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic            vld;
    logic            merge_hit;
    logic [IDXW-1:0] merge_idx;
    logic            free_hit;
    logic [IDXW-1:0] free_idx;
    logic            glow_hit;
    logic [IDXW-1:0] glow_idx;
    logic [31:0]     glow_tag;
    logic            any_hit;
    logic [IDXW-1:0] any_idx;
    logic [31:0]     any_tag;
    logic [CNTW-1:0] cnt;
    logic            rd_active;
    logic [1:0]      rd_class;
    logic [14:0]     rd_strength;
    logic [47:0]     rd_point;
    logic [47:0]     rd_normal;
    logic [47:0]     rd_tangent;
    logic [15:0]     rd_radius;
    logic [31:0]     rd_birth;
  } srch_t;

  // slot write command
  typedef struct packed {
    logic            en;
    logic            merge;
    logic [IDXW-1:0] idx;
    logic [31:0]     tag;
  } wr_t;

endpackage

// File: rtl/core/dsme_cell.sv
// One slot of the table: holds its mark and updates the passing search record.
module dsme_cell import dsme_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [IDXW-1:0] my_idx,
  input  item_t           item,
  input  srch_t           rin,
  input  wr_t             wr,
  output srch_t           rout
);

  logic        live;
  logic [1:0]  kind;
  logic [47:0] where_at;
  logic [47:0] facing;
  logic [47:0] slide;
  logic [15:0] size_of_mark;
  logic [14:0] level;
  logic [31:0] born;
  logic [31:0] age_tag;

  srch_t rout_next;

  logic signed [16:0] dx, dy, dz;
  logic [16:0] ax, ay, az;
  logic [35:0] d2;
  logic        near;
  logic        expire;
  logic        live_after;
  logic        sel_me;
  logic        wr_me;
  logic [15:0] lvl_sum;

  // distance test, squares are independent of each other
  always_comb begin
    dx = 17'(signed'(item.point[15:0]))  - 17'(signed'(where_at[15:0]));
    dy = 17'(signed'(item.point[31:16])) - 17'(signed'(where_at[31:16]));
    dz = 17'(signed'(item.point[47:32])) - 17'(signed'(where_at[47:32]));
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    az = dz[16] ? 17'(-dz) : 17'(dz);
    d2 = 36'(34'(ax) * 34'(ax)) + 36'(34'(ay) * 34'(ay)) + 36'(34'(az) * 34'(az));
    near = ({4'd0, d2, 8'd0} <= item.reach2);
  end

  assign expire     = live && (kind == CLS_GLOW) && ((item.now - born) > item.lifetime);
  assign live_after = live && !expire;
  assign sel_me     = (32'(item.sel) == 32'(my_idx));
  assign wr_me      = wr.en && (wr.idx == my_idx);
  assign lvl_sum    = 16'(level) + 16'(item.amt);

  // record update
  always_comb begin
    rout_next = rin;
    if (rin.vld) begin
      unique case (item.op)
        OP_ADD: begin
          if (item.persist && !rin.merge_hit && live && kind == item.cls && near) begin
            rout_next.merge_hit = 1'b1;
            rout_next.merge_idx = my_idx;
          end
          if (!live && !rin.free_hit) begin
            rout_next.free_hit = 1'b1;
            rout_next.free_idx = my_idx;
          end
          if (kind == CLS_GLOW && (!rin.glow_hit || age_tag < rin.glow_tag)) begin
            rout_next.glow_hit = 1'b1;
            rout_next.glow_idx = my_idx;
            rout_next.glow_tag = age_tag;
          end
          if (!rin.any_hit || age_tag < rin.any_tag) begin
            rout_next.any_hit = 1'b1;
            rout_next.any_idx = my_idx;
            rout_next.any_tag = age_tag;
          end
          rout_next.cnt = rin.cnt + CNTW'(live);
        end
        OP_TICK: begin
          rout_next.cnt = rin.cnt + CNTW'(live_after);
        end
        OP_READ: begin
          if (sel_me) begin
            rout_next.rd_active   = live;
            rout_next.rd_class    = kind;
            rout_next.rd_strength = level;
            rout_next.rd_point    = where_at;
            rout_next.rd_normal   = facing;
            rout_next.rd_tangent  = slide;
            rout_next.rd_radius   = size_of_mark;
            rout_next.rd_birth    = born;
          end
          rout_next.cnt = rin.cnt + CNTW'(live);
        end
        default: begin
          rout_next.cnt = rin.cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rout.vld <= 1'b0;
    end else begin
      rout <= rout_next;
    end
  end

  // slot active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (wr_me && !wr.merge) begin
      live <= 1'b1;
    end else if (rin.vld && item.op == OP_TICK && expire) begin
      live <= 1'b0;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (wr_me) begin
      born    <= item.now;
      facing  <= item.normal;
      slide   <= item.tangent;
      age_tag <= wr.tag;
      if (wr.merge) begin
        level <= (lvl_sum > 16'(FULL_LEVEL)) ? FULL_LEVEL : lvl_sum[14:0];
      end else begin
        level        <= item.amt;
        kind         <= item.cls;
        where_at     <= item.point;
        size_of_mark <= item.radius;
      end
    end
  end

endmodule

// File: rtl/core/decal_slot_merge_evict_table.sv
// Top level of the mark slot table: item capture, cell row, commit and result.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  command  | start / busy           | op, pos_x..z, surf_normal, slip_dir, ...
//  result   | done (one-cycle pulse) | slot_used, action, live_count, rd_*
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every item passes from start to done in order: the ST_REACH and ST_SQ states
// form the squared merge reach, then the search record walks the cell row one
// cell per cycle, and the slot write commits at the edge that registers done.
// Reset clears all active flags and the age counter at once; no clearing pass.
// The result cannot be stalled; the next item may be accepted during done.
// An item with op 3 is accepted and dropped with no result.
module decal_slot_merge_evict_table import dsme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [47:0] surf_normal,
  input  logic [47:0] slip_dir,
  input  logic [15:0] mark_radius,
  input  logic signed [15:0] strength,
  input  logic [1:0]  mark_class,
  input  logic [31:0] time_now,
  input  logic [3:0]  slot_sel,
  output logic        done,
  output logic [3:0]  slot_used,
  output logic [2:0]  action,
  output logic [4:0]  live_count,
  output logic        rd_active,
  output logic [1:0]  rd_class,
  output logic [14:0] rd_strength,
  output logic [47:0] rd_point,
  output logic [47:0] rd_normal,
  output logic [47:0] rd_tangent,
  output logic [15:0] rd_radius,
  output logic [31:0] rd_birth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;
  logic [7:0]  merge_factor;
  logic [31:0] glow_lifetime;
  logic [31:0] tag_next;
  item_t       item;
  logic [23:0] reach;
  srch_t       rec [SLOTS+1];
  wr_t         wr;
  logic        accept;
  logic        fin;
  logic        launch;
  logic [1:0]  cls_in;
  logic [14:0] amt_in;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign fin       = rec[SLOTS].vld;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_factor  <= 8'd16;
      glow_lifetime <= 32'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MERGE_FACTOR: merge_factor  <= cfg_data[7:0];
        REG_GLOW_LIFE:    glow_lifetime <= cfg_data;
        default:          ;
      endcase
    end
  end

  // input conditioning
  always_comb begin
    cls_in = (mark_class == CLS_RSVD) ? CLS_GLOW : mark_class;
    if (strength < 0) begin
      amt_in = 15'd0;
    end else if (strength > signed'(17'(FULL_LEVEL))) begin
      amt_in = FULL_LEVEL;
    end else begin
      amt_in = strength[14:0];
    end
  end

  // item capture and reach squaring
  always_ff @(posedge clk) begin
    if (accept) begin
      item.op       <= op;
      item.cls      <= cls_in;
      item.persist  <= (cls_in == CLS_SCORCH) || (cls_in == CLS_SCUFF);
      item.point    <= {pos_z, pos_y, pos_x};
      item.normal   <= surf_normal;
      item.tangent  <= (cls_in == CLS_SCUFF) ? slip_dir : 48'd0;
      item.radius   <= mark_radius;
      item.amt      <= amt_in;
      item.now      <= time_now;
      item.sel      <= slot_sel;
      item.lifetime <= glow_lifetime;
    end
    if (state == ST_REACH) begin
      reach <= 24'(merge_factor) * 24'(item.radius);
    end
    if (state == ST_SQ) begin
      item.reach2 <= 48'(reach) * 48'(reach);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && op != OP_NONE) state_next = ST_REACH;
      ST_REACH: state_next = ST_SQ;
      ST_SQ:    state_next = ST_SCAN;
      ST_SCAN:  if (fin) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // launch pulse, registered at the same edge that forms the squared reach
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= (state == ST_SQ);
    end
  end

  // seed record, launched once the reach is ready
  always_comb begin
    rec[0]     = '0;
    rec[0].vld = launch;
  end

  // row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    dsme_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .my_idx (IDXW'(i)),
      .item   (item),
      .rin    (rec[i]),
      .wr     (wr),
      .rout   (rec[i+1])
    );
  end

  // commit: choose the target slot from the finished record
  always_comb begin
    wr.en    = fin && (item.op == OP_ADD);
    wr.merge = rec[SLOTS].merge_hit;
    wr.tag   = tag_next;
    if (rec[SLOTS].merge_hit) begin
      wr.idx = rec[SLOTS].merge_idx;
    end else if (rec[SLOTS].free_hit) begin
      wr.idx = rec[SLOTS].free_idx;
    end else if (rec[SLOTS].glow_hit) begin
      wr.idx = rec[SLOTS].glow_idx;
    end else begin
      wr.idx = rec[SLOTS].any_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_next <= 32'd0;
    end else if (wr.en) begin
      tag_next <= tag_next + 32'd1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rd_active   <= rec[SLOTS].rd_active;
      rd_class    <= rec[SLOTS].rd_class;
      rd_strength <= rec[SLOTS].rd_strength;
      rd_point    <= rec[SLOTS].rd_point;
      rd_normal   <= rec[SLOTS].rd_normal;
      rd_tangent  <= rec[SLOTS].rd_tangent;
      rd_radius   <= rec[SLOTS].rd_radius;
      rd_birth    <= rec[SLOTS].rd_birth;
      live_count  <= 5'(rec[SLOTS].cnt);
      unique case (item.op)
        OP_ADD: begin
          slot_used <= 4'(wr.idx);
          if (rec[SLOTS].merge_hit) begin
            action <= ACT_MERGE;
          end else if (rec[SLOTS].free_hit) begin
            action     <= ACT_FILL;
            live_count <= 5'(rec[SLOTS].cnt + CNTW'(1));
          end else if (rec[SLOTS].glow_hit) begin
            action <= ACT_EVICT_GLOW;
          end else begin
            action <= ACT_EVICT_OLD;
          end
        end
        OP_TICK: begin
          slot_used <= 4'd0;
          action    <= ACT_TICK;
        end
        default: begin
          slot_used <= item.sel;
          action    <= ACT_READ;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fin_in_scan: assert property (@(posedge clk) disable iff (rst)
    fin |-> state == ST_SCAN)
    else $error("search record finished outside scan");
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SCAN))
    else $error("result strobe without a finished scan");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> live_count <= 5'(SLOTS))
    else $error("live count beyond table size");
  a_start_reach: assert property (@(posedge clk) disable iff (rst)
    (accept && op != OP_NONE) |=> state == ST_REACH)
    else $error("accepted item did not start reach stage");
`endif

endmodule

// File: bench/tb_decal_slot_merge_evict_table.sv
// Self-checking testbench for the mark slot table: random and directed items, running predictor.
module tb_decal_slot_merge_evict_table;
  import dsme_pkg::*;

  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam logic [1:0] CLS_SPARE = 2'd3;
  localparam int SETTLE = SLOTS + 12;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] px, py, pz;
    logic [47:0]        nrm, tng;
    logic [15:0]        rad;
    logic signed [15:0] str;
    logic [1:0]         cls;
    logic [31:0]        tnow;
    logic [3:0]         sel;
  } mark_cmd_t;

  typedef struct {
    logic [3:0]  slot;
    logic [2:0]  act;
    logic [4:0]  cnt;
    logic        ractive;
    logic [1:0]  rclass;
    logic [14:0] rlevel;
    logic [47:0] rpoint, rnormal, rtangent;
    logic [15:0] rradius;
    logic [31:0] rbirth;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] op = '0;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0, strength = '0;
  logic [47:0] surf_normal = '0, slip_dir = '0;
  logic [15:0] mark_radius = '0;
  logic [1:0]  mark_class = '0;
  logic [31:0] time_now = '0;
  logic [3:0]  slot_sel = '0;
  logic [3:0]  slot_used;
  logic [2:0]  action;
  logic [4:0]  live_count;
  logic        rd_active;
  logic [1:0]  rd_class;
  logic [14:0] rd_strength;
  logic [47:0] rd_point, rd_normal, rd_tangent;
  logic [15:0] rd_radius;
  logic [31:0] rd_birth;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  decal_slot_merge_evict_table dut (.*);

  always #6 clk = ~clk;

  // shadow copy of the table
  logic [7:0]  mf_q = 8'd16;
  logic [31:0] life_q = 32'd1000;
  logic        sh_live [SLOTS];
  logic        sh_seen [SLOTS];
  logic [1:0]  sh_kind [SLOTS];
  logic [47:0] sh_point [SLOTS], sh_normal [SLOTS], sh_tangent [SLOTS];
  logic [15:0] sh_radius [SLOTS];
  logic [14:0] sh_level [SLOTS];
  logic [31:0] sh_born [SLOTS], sh_tag [SLOTS];
  logic [31:0] tag_ctr = '0;

  mark_cmd_t    pend_q [$];
  slot_report_t report_q [$];
  mark_cmd_t    cur;
  int errors = 0, n_done = 0, idle_left = 0;
  int n_act [8];

  function automatic longint unsigned sq_gap(logic signed [15:0] a, logic signed [15:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  function automatic int seen_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (sh_seen[i]) n++;
    return n;
  endfunction

  // apply one accepted item to the shadow table and queue its report; op 3 queues none
  function automatic void table_step(mark_cmd_t c);
    slot_report_t r;
    logic [47:0] pt, tg;
    logic [14:0] amt;
    logic [1:0] k;
    longint unsigned reach, reach2, d2;
    int tgt, glow, any, n;
    logic hit;
    r = '{default: '0};
    if (c.op == OP_SPARE) return;
    if (c.op == OP_ADD) begin
      pt  = {c.pz, c.py, c.px};
      amt = (c.str < 0) ? 15'd0 : (c.str > 16384) ? FULL_LEVEL : 15'(c.str);
      k   = (c.cls == CLS_SPARE) ? CLS_GLOW : c.cls;
      tg  = (k == CLS_SCUFF) ? c.tng : 48'd0;
      hit = 1'b0;
      tgt = -1;
      if (k == CLS_SCORCH || k == CLS_SCUFF) begin
        reach  = longint'(mf_q) * longint'(c.rad);
        reach2 = reach * reach;
        for (int i = 0; i < SLOTS && !hit; i++) begin
          if (!sh_live[i] || sh_kind[i] != k) continue;
          d2 = sq_gap(c.px, sh_point[i][15:0]) + sq_gap(c.py, sh_point[i][31:16])
             + sq_gap(c.pz, sh_point[i][47:32]);
          if (d2 * 256 <= reach2) begin
            hit = 1'b1;
            tgt = i;
          end
        end
      end
      if (hit) begin
        sh_level[tgt]   = (sh_level[tgt] + amt > 16384) ? FULL_LEVEL : sh_level[tgt] + amt;
        sh_born[tgt]    = c.tnow;
        sh_normal[tgt]  = c.nrm;
        sh_tangent[tgt] = tg;
        sh_tag[tgt]     = tag_ctr++;
        r.act = ACT_MERGE;
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!sh_live[i]) tgt = i;
        if (tgt >= 0) r.act = ACT_FILL;
        else begin
          glow = -1;
          any  = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (sh_tag[i] < sh_tag[any]) any = i;
            if (sh_kind[i] == CLS_GLOW && (glow < 0 || sh_tag[i] < sh_tag[glow])) glow = i;
          end
          if (glow >= 0) begin
            tgt = glow;
            r.act = ACT_EVICT_GLOW;
          end else begin
            tgt = any;
            r.act = ACT_EVICT_OLD;
          end
        end
        sh_live[tgt] = 1'b1;
        sh_seen[tgt] = 1'b1;
        sh_kind[tgt] = k;
        sh_point[tgt] = pt;
        sh_normal[tgt] = c.nrm;
        sh_tangent[tgt] = tg;
        sh_radius[tgt] = c.rad;
        sh_level[tgt] = amt;
        sh_born[tgt] = c.tnow;
        sh_tag[tgt] = tag_ctr++;
      end
      r.slot = 4'(tgt);
    end else if (c.op == OP_TICK) begin
      for (int i = 0; i < SLOTS; i++)
        if (sh_live[i] && sh_kind[i] == CLS_GLOW && (c.tnow - sh_born[i]) > life_q)
          sh_live[i] = 1'b0;
      r.act = ACT_TICK;
    end else begin
      r.slot     = c.sel;
      r.act      = ACT_READ;
      r.ractive  = sh_live[c.sel];
      r.rclass   = sh_kind[c.sel];
      r.rlevel   = sh_level[c.sel];
      r.rpoint   = sh_point[c.sel];
      r.rnormal  = sh_normal[c.sel];
      r.rtangent = sh_tangent[c.sel];
      r.rradius  = sh_radius[c.sel];
      r.rbirth   = sh_born[c.sel];
    end
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (sh_live[i]) n++;
    r.cnt = 5'(n);
    n_act[r.act]++;
    report_q.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // driver: start held until the block takes the item
  always @(posedge clk) begin
    logic nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      nxt = start;
      if (start && !busy) begin
        table_step(cur);
        nxt = 1'b0;
        idle_left = pick_gap();
      end
      if (!nxt) begin
        if (idle_left > 0) idle_left--;
        else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          // never read a slot that was never written
          if (cur.op == OP_READ && !sh_seen[cur.sel]) begin
            if (seen_count() == 0) cur.op = OP_TICK;
            else cur.sel = 4'($urandom_range(0, seen_count() - 1));
          end
          op <= cur.op;
          pos_x <= cur.px;
          pos_y <= cur.py;
          pos_z <= cur.pz;
          surf_normal <= cur.nrm;
          slip_dir <= cur.tng;
          mark_radius <= cur.rad;
          strength <= cur.str;
          mark_class <= cur.cls;
          time_now <= cur.tnow;
          slot_sel <= cur.sel;
          nxt = 1'b1;
        end
      end
      start <= nxt;
    end
  end

  function automatic void cmp(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, nm, e, a);
    end
  endfunction

  // monitor: every done pulse against the oldest expectation
  always @(posedge clk) begin
    slot_report_t e;
    if (!rst && done) begin
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual slot %0d action %0d",
                 $time, slot_used, action);
      end else begin
        e = report_q.pop_front();
        n_done++;
        cmp("slot_used", e.slot, slot_used);
        cmp("action", e.act, action);
        cmp("live_count", e.cnt, live_count);
        cmp("rd_active", e.ractive, rd_active);
        cmp("rd_class", e.rclass, rd_class);
        cmp("rd_strength", e.rlevel, rd_strength);
        cmp("rd_point", e.rpoint, rd_point);
        cmp("rd_normal", e.rnormal, rd_normal);
        cmp("rd_tangent", e.rtangent, rd_tangent);
        cmp("rd_radius", e.rradius, rd_radius);
        cmp("rd_birth", e.rbirth, rd_birth);
      end
    end
  end

  // stimulus generation
  logic [31:0] clock_base = 32'd100;
  logic signed [15:0] ctr_x [4], ctr_y [4], ctr_z [4];

  function automatic mark_cmd_t blank_cmd(logic [1:0] o);
    mark_cmd_t c;
    c = '{op: o, px: '0, py: '0, pz: '0, nrm: '0, tng: '0, rad: 16'd100, str: 16'sd4000,
          cls: CLS_SCORCH, tnow: clock_base, sel: '0};
    return c;
  endfunction

  function automatic mark_cmd_t rand_cmd();
    mark_cmd_t c;
    int r, k;
    r = $urandom_range(0, 99);
    c = blank_cmd(r < 60 ? OP_ADD : r < 76 ? OP_TICK : r < 96 ? OP_READ : OP_SPARE);
    clock_base += $urandom_range(0, 30);
    if ($urandom_range(0, 49) == 0) clock_base += $urandom;
    c.tnow = ($urandom_range(0, 9) == 0) ? 32'($urandom) : clock_base;
    c.nrm  = {16'($urandom), 32'($urandom)};
    c.tng  = {16'($urandom), 32'($urandom)};
    c.cls  = 2'($urandom_range(0, 3));
    c.sel  = 4'($urandom);
    r = $urandom_range(0, 9);
    c.str = (r < 2) ? 16'($urandom) : 16'($urandom_range(0, 9000));
    if ($urandom_range(0, 2) > 0) begin
      // near a cluster centre so merges happen
      k = $urandom_range(0, 3);
      r = $urandom_range(0, 9) == 0 ? 0 : 40;
      c.px = ctr_x[k] + 16'($urandom_range(0, r) - r / 2);
      c.py = ctr_y[k] + 16'($urandom_range(0, r) - r / 2);
      c.pz = ctr_z[k] + 16'($urandom_range(0, r) - r / 2);
      c.rad = 16'($urandom_range(0, 300));
    end else begin
      c.px = 16'($urandom);
      c.py = 16'($urandom);
      c.pz = 16'($urandom);
      c.rad = 16'($urandom);
    end
    return c;
  endfunction

  task automatic fill_random(int n);
    for (int i = 0; i < 4; i++) begin
      ctr_x[i] = 16'($urandom);
      ctr_y[i] = 16'($urandom);
      ctr_z[i] = 16'($urandom);
    end
    for (int i = 0; i < n; i++) pend_q.push_back(rand_cmd());
  endtask

  task automatic settle();
    while (pend_q.size() != 0 || start || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MERGE_FACTOR) mf_q = val[7:0];
    else life_q = val;
  endtask

  // directed opening: extremes, classes, ops and the odd cases
  task automatic fill_directed();
    mark_cmd_t c;
    pend_q.push_back(blank_cmd(OP_TICK));
    c = blank_cmd(OP_ADD);
    c.str = 16'sh8000; c.px = 16'sh8000; c.py = 16'sh7fff; c.pz = '0;
    c.rad = 16'hffff; c.nrm = '1; c.tng = '1; c.cls = CLS_SCORCH;
    pend_q.push_back(c);
    c.str = 16'sh7fff; c.tnow = 32'hffffffff;
    pend_q.push_back(c);                       // merges, saturates
    c.str = 16'sd16384; c.cls = CLS_SCUFF; c.px = 16'sh7fff; c.py = 16'sh8000;
    pend_q.push_back(c);
    c.str = 16'sd16385;
    pend_q.push_back(c);
    c.cls = CLS_SPARE; c.rad = '0; c.str = '0;
    pend_q.push_back(c);                       // stored as glow
    c.cls = CLS_GLOW; c.tnow = 32'd0; c.str = 16'sd1;
    pend_q.push_back(c);
    c = blank_cmd(OP_ADD); c.cls = CLS_SCORCH; c.rad = 16'd0;
    pend_q.push_back(c);
    pend_q.push_back(c);                       // zero reach, exact point merges
    c = blank_cmd(OP_SPARE);
    pend_q.push_back(c);
    for (int s = 0; s < 6; s++) begin
      c = blank_cmd(OP_READ); c.sel = 4'(s);
      pend_q.push_back(c);
    end
    c = blank_cmd(OP_TICK); c.tnow = 32'd5000;
    pend_q.push_back(c);                       // expires glows
    c.op = OP_READ; c.sel = 4'd4;
    pend_q.push_back(c);                       // slot 4 holds a scorch mark and stays live
    c = blank_cmd(OP_READ); c.sel = 4'd15;
    pend_q.push_back(c);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_live[i] = 1'b0;
      sh_seen[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) n_act[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    fill_directed();
    settle();
    write_reg(REG_MERGE_FACTOR, 32'd255);
    write_reg(REG_GLOW_LIFE, 32'd50);
    fill_random(300);
    settle();
    write_reg(REG_MERGE_FACTOR, 32'd0);
    write_reg(REG_GLOW_LIFE, 32'd0);
    fill_random(250);
    settle();
    write_reg(REG_MERGE_FACTOR, 32'd40);
    write_reg(REG_GLOW_LIFE, 32'hffffffff);
    fill_random(300);
    settle();
    write_reg(REG_MERGE_FACTOR, 32'd16);
    write_reg(REG_GLOW_LIFE, 32'd1000);
    fill_random(300);
    settle();
    $display("Results checked: %0d (merge %0d, fill %0d, evict glow %0d, evict oldest %0d)",
             n_done, n_act[ACT_MERGE], n_act[ACT_FILL], n_act[ACT_EVICT_GLOW],
             n_act[ACT_EVICT_OLD]);
    $display("Ticks %0d, reads %0d, over five register settings", n_act[ACT_TICK],
             n_act[ACT_READ]);
    if (errors == 0 && report_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 2000000);
    $display("Timeout waiting for results");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dsme_pkg.sv
rtl/core/dsme_cell.sv
rtl/core/decal_slot_merge_evict_table.sv
bench/tb_decal_slot_merge_evict_table.sv
